// ----- sv/ctsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsp_pkg: clause table section parser shared definitions
// Beat types, command format between parser and result stage, constants.
// ----------------------------------------------------------------------------
package ctsp_pkg;

  localparam logic [31:0] SECTION_MAGIC   = 32'h4d4c5344;
  localparam logic [15:0] SECTION_VERSION = 16'd3;
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned ENTRY_BYTES     = 20;
  localparam int unsigned ENTRY_WORDS     = 5;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [2:0] ST_ENTRY     = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_BAD_VER   = 3'd4;
  localparam logic [2:0] ST_NO_MATCH  = 3'd5;

  typedef struct packed {
    logic [7:0] section_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] guard_start;
    logic [31:0] try_length;
    logic [31:0] landing_offset;
    logic [31:0] clause_number;
    logic [31:0] entry_kind;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic                             has_entry;
    logic                             has_status;
    logic [2:0]                       status;
    logic [ENTRY_WORDS-1:0][31:0]     words;
  } cmd_t;

endpackage

// ----- sv/clause_table_section_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clause_table_section_parser_unit: clause table section parser
// Parses a byte stream of clause table blocks and returns the entries of the
// block whose address matches the configured code address, plus status beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive item_i and raise push_i; a beat is taken on a
//   clock edge with push_i high and full_o low. One byte per cycle while
//   full_o is low.
//   Result queue side: while empty_o is low the oldest result is on res_o;
//   raise pop_i to take it. A byte may cause up to two results; run_end marks
//   the last result of a byte.
//   Configuration: cfg_data_i is the code address, written on an edge with
//   cfg_valid_i and cfg_ready_o high; cfg_ready_o is always high.
//   Order: the command for a byte enters the queue on the edge that takes the
//   byte, behind older results. The parser updates its phase counters on that edge.
//   Throughput: one byte per cycle while full_o is low. Results drain at one
//   beat per cycle while pop_i is high, from a 4-command queue.
//   Stall: when the receiver holds pop_i low the queue fills and full_o rises,
//   holding the byte stream.
//   Reset: parser returns to the header phase, the queue empties and the code
//   address clears to zero. The final byte of a section also resets the
//   parser, keeping the code address.
// ----------------------------------------------------------------------------
module clause_table_section_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  ctsp_pkg::in_item_t item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output ctsp_pkg::result_t  res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [63:0]        cfg_data_i
);
  import ctsp_pkg::*;

  logic [63:0] code_address_q;
  logic        accept;
  logic        cmd_valid;
  cmd_t        cmd;
  cmd_t        head;
  logic        head_pop;
  logic        q_full;
  logic        q_empty;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full;
  assign empty_o     = q_empty;
  assign accept      = push_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_address_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      code_address_q <= cfg_data_i;
    end
  end

  ctsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item_i),
    .code_address_i (code_address_q),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  ctsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (head_pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  ctsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop_i        (pop_i),
    .res_o        (res_o)
  );

  a_status_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> res_o.status <= ST_NO_MATCH)
    else $error("result status out of range");

  a_status_zero_words : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.status != ST_ENTRY) |->
      (res_o.guard_start == '0 && res_o.entry_kind == '0 && res_o.run_end))
    else $error("status beat carries entry words or is not last");

  a_cmd_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (head.has_entry || head.has_status))
    else $error("queued command with no beat");

  a_entry_then_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !res_o.run_end) |=> (!empty_o && res_o.status != ST_ENTRY))
    else $error("first beat of a pair not followed by its status");

endmodule

// ----- sv/ctsp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsp_front: section byte parser
// Tracks header, entry, skip and ignore phases and turns a byte that ends an entry or gives a status into a command.
// ----------------------------------------------------------------------------
module ctsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ctsp_pkg::in_item_t item_i,
  input  logic [63:0]       code_address_i,
  output logic              cmd_valid_o,
  output ctsp_pkg::cmd_t    cmd_o
);
  import ctsp_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_ENTRIES = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;
  localparam logic [1:0] PH_IGNORE  = 2'd3;

  logic [1:0]                   phase_q, phase_d;
  logic [4:0]                   cnt_q, cnt_d;
  logic [63:0]                  hw_q, hw_d;
  logic [63:0]                  ha_q, ha_d;
  logic [ENTRY_WORDS-1:0][31:0] ew_q, ew_d;
  logic [15:0]                  el_q, el_d;
  logic [20:0]                  sl_q, sl_d;

  logic [7:0]  b;
  logic        fin;
  logic        terminated;
  logic [3:0]  hdr_idx;
  logic [4:0]  ent_idx;
  logic [63:0] addr_full;
  logic [15:0] ver;
  logic [15:0] count;
  cmd_t        cmd;

  assign b         = item_i.section_byte;
  assign fin       = item_i.final_byte;
  assign hdr_idx   = cnt_q[3:0];
  assign ent_idx   = (cnt_q >= 5'(ENTRY_BYTES)) ? 5'd0 : cnt_q;
  assign addr_full = {b, ha_q[55:0]};
  assign ver       = hw_q[47:32];
  assign count     = hw_q[63:48];

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    hw_d       = hw_q;
    ha_d       = ha_q;
    ew_d       = ew_q;
    el_d       = el_q;
    sl_d       = sl_q;
    cmd        = '0;
    terminated = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        if (!hdr_idx[3]) begin
          hw_d[{hdr_idx[2:0], 3'b000} +: 8] = b;
        end else begin
          ha_d[{hdr_idx[2:0], 3'b000} +: 8] = b;
        end
        cnt_d = {1'b0, hdr_idx} + 5'd1;
        if (hdr_idx == 4'(HEADER_BYTES - 1)) begin
          cnt_d = '0;
          if (hw_q[31:0] != SECTION_MAGIC) begin
            cmd.has_status = 1'b1;
            cmd.status     = ST_BAD_MAGIC;
            terminated     = 1'b1;
            phase_d        = PH_IGNORE;
          end else if (ver != SECTION_VERSION) begin
            cmd.has_status = 1'b1;
            cmd.status     = ST_BAD_VER;
            terminated     = 1'b1;
            phase_d        = PH_IGNORE;
          end else if (addr_full != code_address_i) begin
            if (count == '0) begin
              if (fin) begin
                cmd.has_status = 1'b1;
                cmd.status     = ST_NO_MATCH;
                terminated     = 1'b1;
              end
            end else begin
              sl_d    = {1'b0, count, 4'b0000} + {3'b000, count, 2'b00};
              phase_d = PH_SKIP;
            end
          end else if (count == '0) begin
            cmd.has_status = 1'b1;
            cmd.status     = ST_DONE;
            terminated     = 1'b1;
            phase_d        = PH_IGNORE;
          end else begin
            el_d    = count;
            phase_d = PH_ENTRIES;
          end
        end
      end
      PH_SKIP: begin
        if (sl_q != '0) begin
          sl_d = sl_q - 21'd1;
        end
        if (sl_q <= 21'd1) begin
          if (fin) begin
            cmd.has_status = 1'b1;
            cmd.status     = ST_NO_MATCH;
            terminated     = 1'b1;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      end
      PH_ENTRIES: begin
        ew_d[ent_idx[4:2]][{ent_idx[1:0], 3'b000} +: 8] = b;
        cnt_d = ent_idx + 5'd1;
        if (ent_idx == 5'(ENTRY_BYTES - 1)) begin
          cnt_d         = '0;
          cmd.has_entry = 1'b1;
          cmd.words     = {b, ew_q[4][23:0], ew_q[3], ew_q[2], ew_q[1], ew_q[0]};
          if (el_q != '0) begin
            el_d = el_q - 16'd1;
          end
          if (el_q <= 16'd1) begin
            cmd.has_status = 1'b1;
            cmd.status     = ST_DONE;
            terminated     = 1'b1;
            phase_d        = PH_IGNORE;
          end
        end
      end
      PH_IGNORE: begin
        phase_d = PH_IGNORE;
      end
      default: begin
        phase_d = PH_IGNORE;
      end
    endcase
    if (fin) begin
      if (!terminated && phase_d != PH_IGNORE) begin
        cmd.has_status = 1'b1;
        cmd.status     = ST_TRUNCATED;
      end
      phase_d = PH_HEADER;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hw_q <= hw_d;
      ha_q <= ha_d;
      ew_q <= ew_d;
      el_q <= el_d;
      sl_q <= sl_d;
    end
  end

  assign cmd_valid_o = accept_i && (cmd.has_entry || cmd.has_status);
  assign cmd_o       = cmd;

endmodule

// ----- sv/ctsp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsp_queue: command queue
// Short register queue that decouples the parser from the result stage.
// ----------------------------------------------------------------------------
module ctsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctsp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ctsp_pkg::cmd_t head_o
);
  import ctsp_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule

// ----- sv/ctsp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsp_back: result stage
// Expands each queued command into one or two result beats.
// ----------------------------------------------------------------------------
module ctsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ctsp_pkg::cmd_t    head_i,
  output logic              head_pop_o,
  input  logic              pop_i,
  output ctsp_pkg::result_t res_o
);
  import ctsp_pkg::*;

  logic beat_q;
  logic show_entry;
  logic two_beats;
  logic last_beat;
  logic take;

  assign two_beats  = head_i.has_entry && head_i.has_status;
  assign show_entry = head_i.has_entry && !beat_q;
  assign last_beat  = !(two_beats && !beat_q);
  assign take       = pop_i && head_valid_i;
  assign head_pop_o = take && last_beat;

  always_comb begin
    res_o         = '0;
    res_o.status  = show_entry ? ST_ENTRY : head_i.status;
    res_o.run_end = last_beat;
    if (show_entry) begin
      res_o.guard_start    = head_i.words[0];
      res_o.try_length     = head_i.words[1];
      res_o.landing_offset = head_i.words[2];
      res_o.clause_number  = head_i.words[3];
      res_o.entry_kind     = head_i.words[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 1'b0;
    end else if (take) begin
      beat_q <= !last_beat;
    end
  end

endmodule

// ----- tb/clause_table_section_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clause_table_section_parser_unit_tb: self-checking bench for the parser
// Feeds whole sections one byte per beat. First come hand-built sections for
// the corner cases, then random sections under several code addresses. Each
// accepted byte runs through a behavioral parser that queues the entries and
// status beats it should cause. Every popped beat is checked field by field
// against the oldest queued one. Sender gaps and receiver stalls are random;
// long receiver holds that back up the result queue start at set counts of sent bytes.
// ----------------------------------------------------------------------------
module clause_table_section_parser_unit_tb;
  import ctsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned BYTES_PER_PHASE = 100;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_EVERY      = 450;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam logic [63:0] ALL_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {PH_HEADER, PH_ENTRIES, PH_SKIP, PH_IGNORE} parse_phase_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push_i      = 1'b0;
  logic       full_o;
  in_item_t   item_i      = '0;
  logic       empty_o;
  logic       pop_i       = 1'b0;
  result_t    res_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  clause_table_section_parser_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .item_i      (item_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t    pending_bytes[$];
  result_t     expected_results[$];
  int unsigned mismatches = 0;
  int unsigned sent_beats = 0;
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned next_hold_at = HOLD_EVERY;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  logic [15:0] rx_pat  = 16'hFFFF;
  logic        rx_go;

  // parser shadow state
  logic [63:0]  code_addr = '0;
  parse_phase_e parse_phase = PH_HEADER;
  logic [4:0]   unit_bytes = '0;
  logic [63:0]  hdr_word = '0;
  logic [63:0]  hdr_addr = '0;
  logic [31:0]  entry_word[ENTRY_WORDS] = '{default: '0};
  logic [15:0]  entries_remaining = '0;
  logic [20:0]  skip_remaining = '0;

  function automatic result_t make_result(input logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    if (st == ST_ENTRY) begin
      r.guard_start    = entry_word[0];
      r.try_length     = entry_word[1];
      r.landing_offset = entry_word[2];
      r.clause_number  = entry_word[3];
      r.entry_kind     = entry_word[4];
    end
    return r;
  endfunction

  function automatic void parse_section_byte(input in_item_t it);
    result_t     step_res[$];
    logic [3:0]  idx;
    int unsigned eidx;
    logic [63:0] v64;
    logic [31:0] v32;
    logic [31:0] magic;
    logic [15:0] ver;
    logic [15:0] cnt;
    logic        terminated;
    terminated = 1'b0;
    case (parse_phase)
      PH_HEADER: begin
        idx = unit_bytes[3:0];
        if (idx < 8) begin
          v64 = 64'(it.section_byte) << (8 * idx);
          hdr_word = (idx == 0) ? v64 : (hdr_word | v64);
        end else begin
          v64 = 64'(it.section_byte) << (8 * (idx - 8));
          hdr_addr = (idx == 8) ? v64 : (hdr_addr | v64);
        end
        unit_bytes = 5'(idx) + 5'd1;
        if (unit_bytes == HEADER_BYTES) begin
          magic = hdr_word[31:0];
          ver   = hdr_word[47:32];
          cnt   = hdr_word[63:48];
          unit_bytes = '0;
          if (magic != SECTION_MAGIC) begin
            step_res = {step_res, make_result(ST_BAD_MAGIC)};
            terminated = 1'b1;
            parse_phase = PH_IGNORE;
          end else if (ver != SECTION_VERSION) begin
            step_res = {step_res, make_result(ST_BAD_VER)};
            terminated = 1'b1;
            parse_phase = PH_IGNORE;
          end else if (hdr_addr != code_addr) begin
            if (cnt == 0) begin
              if (it.final_byte) begin
                step_res = {step_res, make_result(ST_NO_MATCH)};
                terminated = 1'b1;
              end
            end else begin
              skip_remaining = 21'(int'(cnt) * ENTRY_BYTES);
              parse_phase = PH_SKIP;
            end
          end else if (cnt == 0) begin
            step_res = {step_res, make_result(ST_DONE)};
            terminated = 1'b1;
            parse_phase = PH_IGNORE;
          end else begin
            entries_remaining = cnt;
            parse_phase = PH_ENTRIES;
          end
        end
      end
      PH_SKIP: begin
        if (skip_remaining > 0) skip_remaining--;
        if (skip_remaining == 0) begin
          if (it.final_byte) begin
            step_res = {step_res, make_result(ST_NO_MATCH)};
            terminated = 1'b1;
          end else begin
            parse_phase = PH_HEADER;
          end
        end
      end
      PH_ENTRIES: begin
        eidx = unit_bytes;
        if (eidx >= ENTRY_BYTES) eidx = 0;
        v32 = 32'(it.section_byte) << (8 * (eidx % 4));
        entry_word[eidx / 4] = (eidx % 4 == 0) ? v32 : (entry_word[eidx / 4] | v32);
        unit_bytes = 5'(eidx + 1);
        if (unit_bytes == ENTRY_BYTES) begin
          unit_bytes = '0;
          step_res = {step_res, make_result(ST_ENTRY)};
          if (entries_remaining > 0) entries_remaining--;
          if (entries_remaining == 0) begin
            step_res = {step_res, make_result(ST_DONE)};
            terminated = 1'b1;
            parse_phase = PH_IGNORE;
          end
        end
      end
      default: parse_phase = PH_IGNORE;
    endcase
    if (it.final_byte) begin
      if (!terminated && parse_phase != PH_IGNORE)
        step_res = {step_res, make_result(ST_TRUNCATED)};
      parse_phase = PH_HEADER;
      unit_bytes = '0;
      hdr_word = '0;
      hdr_addr = '0;
      entry_word = '{default: '0};
      entries_remaining = '0;
      skip_remaining = '0;
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].run_end = 1'b1;
    expected_results = {expected_results, step_res};
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: exp st=%0d %h %h %h %h %h end=%0b, got st=%0d %h %h %h %h %h end=%0b",
               $realtime, what, want.status, want.guard_start, want.try_length,
               want.landing_offset, want.clause_number, want.entry_kind, want.run_end,
               got.status, got.guard_start, got.try_length, got.landing_offset,
               got.clause_number, got.entry_kind, got.run_end);
  endfunction

  // section building; fill < 0 gives random bytes
  function automatic void put_bytes(ref logic [7:0] sec[$], input int n, input int fill);
    for (int i = 0; i < n; i++)
      sec = {sec, ((fill < 0) ? 8'($urandom) : 8'(fill))};
  endfunction

  function automatic void put_header(ref logic [7:0] sec[$], input logic [31:0] magic,
                                     input logic [15:0] ver, input logic [15:0] cnt,
                                     input logic [63:0] addr);
    logic [127:0] h;
    h = {addr, cnt, ver, magic};
    for (int i = 0; i < 16; i++) sec = {sec, h[8*i +: 8]};
  endfunction

  function automatic int queue_section(ref logic [7:0] sec[$]);
    in_item_t it;
    foreach (sec[i]) begin
      it.section_byte = sec[i];
      it.final_byte   = (i == sec.size() - 1);
      pending_bytes = {pending_bytes, it};
    end
    return sec.size();
  endfunction

  function automatic int queue_random_section();
    logic [7:0]  sec[$];
    int unsigned kind;
    int unsigned nblk;
    int unsigned cut;
    logic [31:0] magic;
    logic [15:0] ver;
    logic [15:0] cnt;
    logic [63:0] addr;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      put_bytes(sec, $urandom_range(1, 40), -1);
    end else begin
      nblk = $urandom_range(1, 3);
      for (int b = 0; b < nblk; b++) begin
        magic = SECTION_MAGIC;
        ver   = SECTION_VERSION;
        if ($urandom_range(0, 15) == 0) magic ^= 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 15) == 0) ver = 16'($urandom);
        cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 12))
                                          : 16'($urandom_range(0, 3));
        if ((b == nblk - 1 && $urandom_range(0, 3) != 0) || $urandom_range(0, 7) == 0)
          addr = code_addr;
        else if ($urandom_range(0, 1) == 0)
          addr = code_addr ^ (64'd1 << $urandom_range(0, 63));
        else
          addr = {$urandom, $urandom};
        put_header(sec, magic, ver, cnt, addr);
        put_bytes(sec, 20 * cnt, -1);
      end
      if ($urandom_range(0, 3) == 0) put_bytes(sec, $urandom_range(1, 10), -1);
      if (kind <= 2 && sec.size() > 1) begin
        cut = $urandom_range(1, sec.size() - 1);
        while (sec.size() > cut) void'(sec.pop_back());
      end
    end
    return queue_section(sec);
  endfunction

  task automatic write_code_address(input logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    code_addr = value;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || push_i || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // byte sender: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      item_i <= '0;
    end else begin
      if (push_i && !full_o) begin
        parse_section_byte(item_i);
        void'(pending_bytes.pop_front());
        sent_beats <= sent_beats + 1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else if (!push_i && gap_left > 0) begin
        gap_left--;
      end
      if (gap_left == 0 && pending_bytes.size() != 0) begin
        push_i <= 1'b1;
        item_i <= pending_bytes[0];
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // long receiver hold so the result queue fills and the input stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      next_hold_at <= HOLD_EVERY;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (sent_beats >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
    end
  end

  // result receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t want;
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (expected_results.size() == 0) begin
          want = '0;
          note_mismatch("unexpected beat", want, res_o);
        end else begin
          want = expected_results.pop_front();
          if (res_o.status !== want.status || res_o.guard_start !== want.guard_start ||
              res_o.try_length !== want.try_length ||
              res_o.landing_offset !== want.landing_offset ||
              res_o.clause_number !== want.clause_number ||
              res_o.entry_kind !== want.entry_kind || res_o.run_end !== want.run_end)
            note_mismatch("wrong beat", want, res_o);
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(16, 128);
        rx_pat  = 16'($urandom) | 16'd1;
      end else begin
        rx_left--;
        rx_pat = {rx_pat[14:0], rx_pat[15]};
      end
      case (rx_mode)
        0:       rx_go = 1'b1;
        1:       rx_go = 1'($urandom_range(0, 1));
        default: rx_go = rx_pat[0];
      endcase
      pop_i <= (hold_left == 0) && rx_go;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  sec[$];
    logic [63:0] phase_addr[5];
    int unsigned phase_bytes;
    phase_addr = '{ALL_ONES, 64'h8000_0000_0000_0000, {$urandom, $urandom}, 64'h0,
                   {$urandom, $urandom}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner cases under the reset code address of zero
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd1, 64'h0);
    put_bytes(sec, 20, 8'hFF);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd2, 64'h0);
    put_bytes(sec, 20, 8'h00);
    put_bytes(sec, 25, -1);
    void'(queue_section(sec)); sec.delete();
    // empty matching block, then ignored tail
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd0, 64'h0);
    put_bytes(sec, 3, -1);
    void'(queue_section(sec)); sec.delete();
    // bad magic, bad version, both bad
    put_header(sec, SECTION_MAGIC ^ 32'h8000_0000, SECTION_VERSION, 16'd1, 64'h0);
    put_bytes(sec, 20, -1);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, 16'd4, 16'd1, 64'h0);
    put_bytes(sec, 20, -1);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, ALL_ONES);
    void'(queue_section(sec)); sec.delete();
    // skipped block ahead of the matching one
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd2, ALL_ONES);
    put_bytes(sec, 40, -1);
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd1, 64'h0);
    put_bytes(sec, 20, -1);
    void'(queue_section(sec)); sec.delete();
    // skip ending on the section end, with and without entries
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd1, ALL_ONES);
    put_bytes(sec, 20, -1);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd0, ALL_ONES);
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd0, ALL_ONES);
    void'(queue_section(sec)); sec.delete();
    // early section ends
    put_bytes(sec, 5, -1);
    void'(queue_section(sec)); sec.delete();
    put_bytes(sec, 1, 8'h44);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd2, 64'h0);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd2, ALL_ONES);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd3, 64'h0);
    put_bytes(sec, 27, -1);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd2, ALL_ONES);
    put_bytes(sec, 25, -1);
    void'(queue_section(sec)); sec.delete();
    // entry completing on the final byte, not the last of its block
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'd2, 64'h0);
    put_bytes(sec, 20, -1);
    void'(queue_section(sec)); sec.delete();
    put_header(sec, SECTION_MAGIC, SECTION_VERSION, 16'hFFFF, 64'h0);
    put_bytes(sec, 20, -1);
    void'(queue_section(sec)); sec.delete();
    wait_idle();

    foreach (phase_addr[p]) begin
      write_code_address(phase_addr[p]);
      @(negedge clk_i);
      phase_bytes = 0;
      while (phase_bytes < BYTES_PER_PHASE) phase_bytes += queue_random_section();
      wait_idle();
    end

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- clause_table_section_parser_unit.f -----
sv/ctsp_pkg.sv
sv/ctsp_front.sv
sv/ctsp_queue.sv
sv/ctsp_back.sv
sv/clause_table_section_parser_unit.sv
tb/clause_table_section_parser_unit_tb.sv
